// File: src/lpd_pkg.sv
`default_nettype none
package lpd_pkg;

    localparam int MAX_FRAME_BYTES = 255;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_BAD_TYPE = 2'd1;
    localparam logic [1:0] STATUS_SHORT = 2'd2;
    localparam logic [1:0] STATUS_NO_PAYLOAD = 2'd3;

    localparam logic [0:0] CFG_KEY_HIGH = 1'd0;
    localparam logic [0:0] CFG_KEY_LOW = 1'd1;

    localparam logic [7:0] A_BLOCK_FLAG = 8'h01;
    localparam logic [8:0] HEADER_BYTES = 9'd9;
    localparam logic [8:0] MIN_FRAME_BYTES = 9'd13;
    localparam logic [3:0] LAST_ROUND = 4'd10;

    typedef struct packed {
        logic [7:0]  cipher_byte;
        logic [3:0]  ks_offset;
        logic        new_block;
        logic        downlink;
        logic [31:0] dev_addr;
        logic [15:0] fcnt;
        logic [7:0]  block_cnt;
        logic        have;
        logic        last;
        logic [1:0]  status;
    } lpd_item_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte 0 of a block sits in bits 127:120
    function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
        return v[127 - 8 * i -: 8];
    endfunction

    function automatic logic [127:0] key_expand(input logic [127:0] rk, input logic [7:0] rcon);
        logic [7:0] k [16];
        logic [127:0] res;
        for (int i = 0; i < 16; i++) k[i] = get_byte(rk, i);
        k[0] = k[0] ^ SBOX[k[13]] ^ rcon;
        k[1] = k[1] ^ SBOX[k[14]];
        k[2] = k[2] ^ SBOX[k[15]];
        k[3] = k[3] ^ SBOX[k[12]];
        for (int i = 4; i < 16; i++) k[i] = k[i] ^ k[i - 4];
        for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = k[i];
        return res;
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] st, input logic final_rnd);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] res;
        for (int i = 0; i < 16; i++) s[i] = get_byte(st, i);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[c * 4 + r] = SBOX[s[((c + r) % 4) * 4 + r]];
        if (!final_rnd)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = t[c * 4];
                a1 = t[c * 4 + 1];
                a2 = t[c * 4 + 2];
                a3 = t[c * 4 + 3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[c * 4]     = a0 ^ all ^ xtime(a0 ^ a1);
                t[c * 4 + 1] = a1 ^ all ^ xtime(a1 ^ a2);
                t[c * 4 + 2] = a2 ^ all ^ xtime(a2 ^ a3);
                t[c * 4 + 3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = t[i];
        return res;
    endfunction

endpackage
`default_nettype wire

// File: src/lpd_if.sv
`default_nettype none
interface lpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;
    modport source (output valid, packet_byte, last_byte, input ready);
    modport sink (input valid, packet_byte, last_byte, output ready);
endinterface

interface lpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] plain_byte;
    logic       last_result;
    logic [1:0] status;
    modport source (output valid, plain_byte, last_result, status, input ready);
    modport sink (input valid, plain_byte, last_result, status, output ready);
endinterface
`default_nettype wire

// File: src/lpd_front.sv
`default_nettype none
module lpd_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    lpd_in_if.sink                 in_ch,
    input  wire logic              fifo_full,
    output logic                   push,
    output lpd_pkg::lpd_item_t     item
);
    import lpd_pkg::*;

    logic [7:0]  pos_reg, pos_next;
    logic [31:0] addr_reg, addr_next;
    logic [15:0] fcnt_reg, fcnt_next;
    logic        dir_reg, dir_next;
    logic [3:0]  opt_reg, opt_next;
    logic        bad_reg, bad_next;
    logic [7:0]  dly_reg [4];
    logic [7:0]  dly_next [4];
    logic [7:0]  blk_reg, blk_next;
    logic [3:0]  off_reg, off_next;

    logic       accept, active, have;
    logic [8:0] len;
    logic [1:0] status;
    logic [2:0] mtype;

    assign in_ch.ready = !fifo_full;
    assign accept = in_ch.valid && !fifo_full;
    assign active = pos_reg != 8'(MAX_FRAME_BYTES);
    assign mtype = in_ch.packet_byte[7:5];
    assign have = active && pos_reg >= 8'd4 && !bad_reg
                  && {1'b0, pos_reg} >= MIN_FRAME_BYTES + {5'd0, opt_reg};
    assign len = active ? {1'b0, pos_reg} + 9'd1 : {1'b0, pos_reg};

    always_comb
    begin
        if (len <= MIN_FRAME_BYTES)
            status = STATUS_SHORT;
        else if (bad_reg)
            status = STATUS_BAD_TYPE;
        else if (len <= MIN_FRAME_BYTES + {5'd0, opt_reg})
            status = STATUS_NO_PAYLOAD;
        else
            status = STATUS_OK;
    end

    always_comb
    begin
        pos_next = pos_reg;
        addr_next = addr_reg;
        fcnt_next = fcnt_reg;
        dir_next = dir_reg;
        opt_next = opt_reg;
        bad_next = bad_reg;
        dly_next = dly_reg;
        blk_next = blk_reg;
        off_next = off_reg;
        if (accept && active)
        begin
            case (pos_reg)
                8'd0:
                begin
                    bad_next = mtype < 3'd2 || mtype > 3'd5;
                    dir_next = mtype[0];
                end
                8'd1: addr_next[7:0] = in_ch.packet_byte;
                8'd2: addr_next[15:8] = in_ch.packet_byte;
                8'd3: addr_next[23:16] = in_ch.packet_byte;
                8'd4: addr_next[31:24] = in_ch.packet_byte;
                8'd5: opt_next = in_ch.packet_byte[3:0];
                8'd6: fcnt_next[7:0] = in_ch.packet_byte;
                8'd7: fcnt_next[15:8] = in_ch.packet_byte;
                default: ;
            endcase
            dly_next[0] = dly_reg[1];
            dly_next[1] = dly_reg[2];
            dly_next[2] = dly_reg[3];
            dly_next[3] = in_ch.packet_byte;
            if (have)
            begin
                if (off_reg == 4'd0)
                    blk_next = blk_reg + 8'd1;
                off_next = off_reg + 4'd1;
            end
            pos_next = pos_reg + 8'd1;
        end
        // closing byte clears all frame state
        if (accept && in_ch.last_byte)
        begin
            pos_next = '0;
            addr_next = '0;
            fcnt_next = '0;
            dir_next = 1'b0;
            opt_next = '0;
            bad_next = 1'b0;
            for (int i = 0; i < 4; i++) dly_next[i] = '0;
            blk_next = '0;
            off_next = '0;
        end
    end

    assign push = accept && (have || in_ch.last_byte);

    always_comb
    begin
        item.cipher_byte = dly_reg[0];
        item.ks_offset = off_reg;
        item.new_block = have && off_reg == 4'd0;
        item.downlink = dir_reg;
        item.dev_addr = addr_reg;
        item.fcnt = fcnt_reg;
        item.block_cnt = blk_reg + 8'd1;
        item.have = have;
        item.last = in_ch.last_byte;
        item.status = in_ch.last_byte ? status : STATUS_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            addr_reg <= '0;
            fcnt_reg <= '0;
            dir_reg <= 1'b0;
            opt_reg <= '0;
            bad_reg <= 1'b0;
            for (int i = 0; i < 4; i++) dly_reg[i] <= '0;
            blk_reg <= '0;
            off_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            addr_reg <= addr_next;
            fcnt_reg <= fcnt_next;
            dir_reg <= dir_next;
            opt_reg <= opt_next;
            bad_reg <= bad_next;
            dly_reg <= dly_next;
            blk_reg <= blk_next;
            off_reg <= off_next;
        end
    end
endmodule
`default_nettype wire

// File: src/lpd_fifo.sv
`default_nettype none
module lpd_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  lpd_pkg::lpd_item_t     wr_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output lpd_pkg::lpd_item_t     head
);
    import lpd_pkg::*;

    lpd_item_t mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign full = count_reg == (FIFO_AW + 1)'(FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end
endmodule
`default_nettype wire

// File: src/lpd_back.sv
`default_nettype none
module lpd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [127:0]      key,
    input  wire logic              head_valid,
    input  lpd_pkg::lpd_item_t     head,
    output logic                   pop,
    lpd_out_if.source              out_ch
);
    import lpd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_ROUND = 1'b1;

    logic         st_reg;
    logic [3:0]   round_reg;
    logic [7:0]   rcon_reg;
    logic [127:0] state_reg, rk_reg, ks_reg;
    logic         ks_ok_reg;
    logic         out_valid_reg;
    logic [7:0]   plain_reg;
    logic         last_reg;
    logic [1:0]   status_reg;

    logic         out_free, start;
    logic [127:0] rk_next, state_next, a_block;
    logic [7:0]   ks_byte;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign start = st_reg == ST_IDLE && head_valid && head.new_block && !ks_ok_reg;
    assign pop = st_reg == ST_IDLE && head_valid && (!head.new_block || ks_ok_reg)
                 && out_free;

    assign a_block = {A_BLOCK_FLAG, 32'h0, 7'h0, head.downlink,
                      head.dev_addr[7:0], head.dev_addr[15:8],
                      head.dev_addr[23:16], head.dev_addr[31:24],
                      head.fcnt[7:0], head.fcnt[15:8], 24'h0, head.block_cnt};

    assign rk_next = key_expand(rk_reg, rcon_reg);
    assign state_next = aes_round(state_reg, round_reg == LAST_ROUND) ^ rk_next;
    assign ks_byte = ks_reg[7'd127 - {head.ks_offset, 3'b000} -: 8];

    assign out_ch.valid = out_valid_reg;
    assign out_ch.plain_byte = plain_reg;
    assign out_ch.last_result = last_reg;
    assign out_ch.status = status_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            state_reg <= a_block ^ key;
            rk_reg <= key;
        end
        else if (st_reg == ST_ROUND)
        begin
            state_reg <= state_next;
            rk_reg <= rk_next;
            if (round_reg == LAST_ROUND)
                ks_reg <= state_next;
        end
        if (pop)
        begin
            plain_reg <= (head.have && head.status == STATUS_OK)
                         ? head.cipher_byte ^ ks_byte : 8'h00;
            last_reg <= head.last;
            status_reg <= head.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            round_reg <= '0;
            rcon_reg <= '0;
            ks_ok_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (st_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        st_reg <= ST_ROUND;
                        round_reg <= 4'd1;
                        rcon_reg <= 8'h01;
                    end
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 4'd1;
                    rcon_reg <= xtime(rcon_reg);
                    if (round_reg == LAST_ROUND)
                    begin
                        st_reg <= ST_IDLE;
                        ks_ok_reg <= 1'b1;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
            // a fresh block serves one item, later items of the block reuse it
            if (pop)
                ks_ok_reg <= 1'b0;
            if (pop)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// File: src/lorawan_payload_decrypt.sv
// LoRaWAN FRMPayload decryption, one frame byte per input transaction.
// in_ch carries packet_byte with last_byte set on the final byte of a frame.
// out_ch carries plain_byte, last_result and status; payload bytes come out
// in order, MIC bytes are held back and dropped, and every frame closes with
// exactly one transaction that has last_result set and the frame status.
// Key: write cfg_index 0 (key_high) and 1 (key_low) while no frame is active.
// A byte that reuses the current keystream block goes through the queue and
// the output register before it shows on out_ch. A byte that opens a new
// 16-byte block waits for the AES round unit: a start step, then ten rounds,
// one per cycle, before it shows on out_ch.
// The parser takes one byte per cycle while the queue has room; a four-entry
// queue between parser and AES back end keeps the parser taking bytes while
// the rounds run.
// Reset clears frame state, the queue and the output register; the key reads
// as zero until written. When the receiver stalls, the output holds, the
// queue fills and in_ch.ready drops once four results are waiting.
`default_nettype none
module lorawan_payload_decrypt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    lpd_in_if.sink           in_ch,
    lpd_out_if.source        out_ch,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import lpd_pkg::*;

    logic [63:0] key_high_reg, key_low_reg;
    logic        push, full, pop, head_valid;
    lpd_item_t   wr_item, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LOW:  key_low_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    lpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .fifo_full (full),
        .push      (push),
        .item      (wr_item)
    );

    lpd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_item    (wr_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    lpd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        ({key_high_reg, key_low_reg}),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_ch     (out_ch)
    );
endmodule
`default_nettype wire

// File: src/lpd_checker.sv
`default_nettype none
module lpd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] plain_byte,
    input wire logic       last_result,
    input wire logic [1:0] status
);
    import lpd_pkg::*;

    a_no_valid_in_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    a_error_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> last_result)
        else $error("error status on a non-closing transaction");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> plain_byte == 8'h00)
        else $error("nonzero byte with error status");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(plain_byte)
        && $stable(last_result) && $stable(status))
        else $error("stalled output changed");
endmodule

bind lorawan_payload_decrypt lpd_checker u_lpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .plain_byte  (out_ch.plain_byte),
    .last_result (out_ch.last_result),
    .status      (out_ch.status)
);
`default_nettype wire
